@@ sv/i2a_pkg.sv @@
`default_nettype none

package i2a_pkg;

    // converted value width (8 to 64)
    localparam int VALUE_WIDTH = 64;

    // decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1
    localparam int NUM_CELLS = (VALUE_WIDTH * 1233) / 4096 + 1;

    localparam int COUNT_W = $clog2(NUM_CELLS + 1);
    localparam int BIT_W   = $clog2(VALUE_WIDTH);
    localparam int PAD_W   = NUM_CELLS * 4;

    // format codes
    localparam logic [1:0] OP_HEX_LOWER = 2'd0;
    localparam logic [1:0] OP_HEX_UPPER = 2'd1;
    localparam logic [1:0] OP_DECIMAL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_EMIT
    } t_state;

    // per-cycle command shared by every cell of the chain
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } t_cell_ctl;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit,
                                                  input logic       upper);
        logic [7:0] base;
        begin
            if (digit < 4'd10) begin
                base = 8'h30;
                digit_to_ascii = base + {4'd0, digit};
            end else begin
                base = upper ? 8'h41 : 8'h61;
                digit_to_ascii = base + {4'd0, digit} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/integer_to_ascii_digits_core.sv @@
`default_nettype none

// channel | direction | handshake            | payload
// input   | in        | i_valid / o_ready    | i_value[63:0], i_operation[1:0]
// output  | out       | o_valid / i_ready    | o_digit_char[7:0], o_last_digit,
//         |           |                      | o_digit_count[4:0]
//
// one value at a time; o_ready is high only while idle
// hex: load, leading-zero trim, then one output beat per digit
// decimal: adds one shift-and-add-3 step per input bit before the trim
// the digit chain moves one place per cycle while it is commanded to
// output stalls hold the chain; synchronous active-low reset returns to idle

module integer_to_ascii_digits_core
    import i2a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_operation,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_digit_char,
    output logic             o_last_digit,
    output logic      [4:0]  o_digit_count
);

    t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_shift;   // bits still to feed, msb first
    logic [BIT_W-1:0]       r_bit;     // bits left minus one
    logic [COUNT_W-1:0]     r_left;    // digits still in the chain
    logic [COUNT_W-1:0]     r_total;   // digit count of this value
    logic                   r_upper;

    t_cell_ctl              w_ctl;
    logic [PAD_W-1:0]       w_pad;
    logic [3:0]             w_digit [NUM_CELLS];
    logic                   w_carry [NUM_CELLS];
    logic [3:0]             w_top;
    logic                   w_accept;

    assign w_pad    = PAD_W'(i_value[VALUE_WIDTH-1:0]);
    assign w_top    = w_digit[NUM_CELLS-1];
    assign w_accept = i_valid && o_ready;

    // cell 0 is the least significant digit; data moves toward the top
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic [3:0] w_load;
        logic       w_bit_in;
        logic [3:0] w_digit_in;

        // hex loads its nibbles directly, decimal starts from zero
        assign w_load = i_operation[1] ? 4'd0 : w_pad[g*4 +: 4];

        if (g == 0) begin : g_first
            assign w_bit_in   = r_shift[VALUE_WIDTH-1];
            assign w_digit_in = 4'd0;
        end else begin : g_rest
            assign w_bit_in   = w_carry[g-1];
            assign w_digit_in = w_digit[g-1];
        end

        i2a_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_load_digit (w_load),
            .i_bit_in     (w_bit_in),
            .i_digit_in   (w_digit_in),
            .o_digit      (w_digit[g]),
            .o_carry      (w_carry[g])
        );
    end

    // next state and chain commands
    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_ctl.load = 1'b1;
                    n_state    = i_operation[1] ? ST_CONV : ST_TRIM;
                end
            end
            ST_CONV: begin
                w_ctl.dabble = 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_left > COUNT_W'(1)) begin
                    w_ctl.shift = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    w_ctl.shift = 1'b1;
                    if (r_left == COUNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_shift <= i_value[VALUE_WIDTH-1:0];
            r_bit   <= BIT_W'(VALUE_WIDTH - 1);
            r_left  <= COUNT_W'(NUM_CELLS);
            r_upper <= (i_operation == OP_HEX_UPPER);
        end else begin
            if (w_ctl.dabble) begin
                r_shift <= r_shift << 1;
                r_bit   <= r_bit - BIT_W'(1);
            end
            if (w_ctl.shift) begin
                r_left <= r_left - COUNT_W'(1);
            end
            // count settles when trimming ends
            if (r_state == ST_TRIM && !w_ctl.shift) begin
                r_total <= r_left;
            end
        end
    end

    assign o_digit_char  = digit_to_ascii(w_top, r_upper);
    assign o_last_digit  = (r_left == COUNT_W'(1));
    assign o_digit_count = 5'(r_total);

endmodule

`default_nettype wire

@@ sv/i2a_cell.sv @@
`default_nettype none

module i2a_cell
    import i2a_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic [3:0] i_load_digit,
    input  wire logic      i_bit_in,
    input  wire logic [3:0] i_digit_in,
    output logic     [3:0] o_digit,
    output logic           o_carry
);

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    // add-3 correction before the shift
    always_comb begin
        w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        o_carry = w_adj[3];
        o_digit = r_digit;
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctl.dabble) begin
            r_digit <= {w_adj[2:0], i_bit_in};
        end else if (i_ctl.shift) begin
            r_digit <= i_digit_in;
        end else begin
            r_digit <= r_digit;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/integer_to_ascii_digits_core_tb.sv @@
`timescale 1ns / 100ps

// expected digit stream for the converter: one entry per output beat
class digit_scoreboard;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
    } digit_beat_t;

    localparam int MAX_DIGITS = 20;

    digit_beat_t expected_digits[$];
    int          mismatches;
    int          digits_checked;

    function new();
        mismatches     = 0;
        digits_checked = 0;
    endfunction

    task report_mismatch(input string what);
        $display("mismatch at digit beat %0d: %s", digits_checked, what);
        mismatches++;
    endtask

    function int pending();
        return expected_digits.size();
    endfunction

    // accepted value: expand it into its expected digit beats
    function void note_value(input logic [63:0] value, input logic [1:0] op);
        logic [127:0] lower_table = "0123456789abcdef";
        logic [127:0] upper_table = "0123456789ABCDEF";
        logic [63:0]  value_mask;
        logic [63:0]  rest;
        logic [63:0]  radix;
        logic [63:0]  rem;
        logic [3:0]   d;
        logic [7:0]   rev [MAX_DIGITS];
        int           n;
        digit_beat_t  beat;
        value_mask = {64{1'b1}} >> (64 - i2a_pkg::VALUE_WIDTH);
        rest  = value & value_mask;
        // bit 1 of the format picks decimal, so the unused code is decimal too
        radix = op[1] ? 64'd10 : 64'd16;
        n = 0;
        do begin
            rem  = rest % radix;
            d    = rem[3:0];
            rev[n] = (op == i2a_pkg::OP_HEX_UPPER) ? upper_table[8*(15-d) +: 8]
                                                   : lower_table[8*(15-d) +: 8];
            n++;
            rest = rest / radix;
        end while (rest != 64'd0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            beat.ch    = rev[k];
            beat.last  = (k == 0);
            beat.count = n[4:0];
            expected_digits.push_back(beat);
        end
    endfunction

    task check_digit(input logic [7:0] ch, input logic last, input logic [4:0] count);
        digit_beat_t want;
        if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected beat char %h last %b count %0d",
                                      ch, last, count));
        end else begin
            want = expected_digits.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("char got %h want %h", ch, want.ch));
            if (last !== want.last)
                report_mismatch($sformatf("last got %b want %b", last, want.last));
            if (count !== want.count)
                report_mismatch($sformatf("count got %0d want %0d", count, want.count));
        end
        digits_checked++;
    endtask

endclass

module integer_to_ascii_digits_core_tb;

    import i2a_pkg::*;

    // format code with no meaning of its own, converted as decimal
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_VALUES = 410;
    localparam int HOLD_AFTER    = 150;   // output beats before the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    // quiet time after the last digit, sized from NUM_CELLS and VALUE_WIDTH
    localparam int DRAIN_CYCLES  = 4 * (NUM_CELLS + VALUE_WIDTH + 4);

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [63:0] i_value     = '0;
    logic [1:0]  i_operation = OP_HEX_LOWER;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [7:0]  o_digit_char;
    logic        o_last_digit;
    logic [4:0]  o_digit_count;

    digit_scoreboard sb = new();

    // sender side: when set, no gaps between values
    bit sender_calm = 1'b0;
    int beats_seen  = 0;

    integer_to_ascii_digits_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_operation   (i_operation),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digit_char  (o_digit_char),
        .o_last_digit  (o_last_digit),
        .o_digit_count (o_digit_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // value with a spread of digit counts: full width, right-shifted, or tiny
    function automatic logic [63:0] random_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return r;
            1:       return r >> $urandom_range(1, 63);
            2:       return r >> $urandom_range(44, 63);
            default: return 64'($urandom_range(0, 20));
        endcase
    endfunction

    function automatic logic [1:0] random_format();
        int r;
        r = $urandom_range(0, 15);
        if (r < 5)
            return OP_HEX_LOWER;
        else if (r < 10)
            return OP_HEX_UPPER;
        else if (r < 15)
            return OP_DECIMAL;
        else
            return OP_UNUSED;
    endfunction

    // present one value and hold it until the block takes the beat
    task automatic send_value(input logic [63:0] value, input logic [1:0] op);
        @(negedge i_clk);
        i_value     = value;
        i_operation = op;
        i_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_value(value, op);
    endtask

    task automatic offer_value(input logic [63:0] value, input logic [1:0] op);
        int gap;
        send_value(value, op);
        gap = sender_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off so the
    // block backs up and drops o_ready while values keep being offered
    initial begin : digit_sink
        int stall_left;
        int calm_left;
        bit calm;
        bit hold_done;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end else begin
                calm_left--;
            end
            if (!hold_done && beats_seen >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready    = 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                sb.check_digit(o_digit_char, o_last_digit, o_digit_count);
                beats_seen++;
            end
        end
    end

    initial begin : value_source
        int calm_left;
        calm_left = 0;

        // reset held low before any value is offered
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero in every format, the unused code included
        offer_value(64'd0, OP_HEX_LOWER);
        offer_value(64'd0, OP_HEX_UPPER);
        offer_value(64'd0, OP_DECIMAL);
        offer_value(64'd0, OP_UNUSED);
        // all ones: 16 hex digits, 20 decimal digits
        offer_value({64{1'b1}}, OP_HEX_LOWER);
        offer_value({64{1'b1}}, OP_HEX_UPPER);
        offer_value({64{1'b1}}, OP_DECIMAL);
        offer_value({64{1'b1}}, OP_UNUSED);
        // every hex letter in both cases
        offer_value(64'h0123_4567_89AB_CDEF, OP_HEX_LOWER);
        offer_value(64'h0123_4567_89AB_CDEF, OP_HEX_UPPER);
        offer_value(64'hFEDC_BA98_7654_3210, OP_HEX_UPPER);
        offer_value(64'h8000_0000_0000_0000, OP_HEX_LOWER);
        offer_value(64'h8000_0000_0000_0000, OP_DECIMAL);
        // digit-count boundaries
        offer_value(64'd1, OP_DECIMAL);
        offer_value(64'd9, OP_DECIMAL);
        offer_value(64'd10, OP_DECIMAL);
        offer_value(64'hF, OP_HEX_LOWER);
        offer_value(64'h10, OP_HEX_UPPER);
        offer_value(64'd9999999999999999999, OP_DECIMAL);
        offer_value(64'd10000000000000000000, OP_DECIMAL);
        offer_value(64'd1234567890, OP_UNUSED);

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (calm_left == 0) begin
                sender_calm = ($urandom_range(0, 2) == 0);
                calm_left   = $urandom_range(20, 60);
            end else begin
                calm_left--;
            end
            offer_value(random_value(), random_format());
        end

        @(negedge i_clk);
        i_valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d digit beats never arrived", sb.pending()));

        if (sb.mismatches == 0) begin
            $display("integer_to_ascii_digits_core_tb OK");
        end else begin
            $display("integer_to_ascii_digits_core_tb NOT OK");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #15_000_000;
        $display("integer_to_ascii_digits_core_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/i2a_pkg.sv
sv/i2a_cell.sv
sv/integer_to_ascii_digits_core.sv
tb/sv/integer_to_ascii_digits_core_tb.sv
